// ===== sv/srti_pkg.sv =====
// Shared types, constants and constant functions of the shaper response table block.
// No dependencies; imported by every module of the block.
`default_nettype none
package srti_pkg;

   localparam int TABLE_DEPTH     = 4000;
   localparam int STEPS_PER_SHAPE = 400;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int POS_LIMIT       = TABLE_DEPTH - 1;
   localparam int ROM_W           = 18;
   localparam int FRAC_W          = 16;
   localparam int QUOT_W          = $clog2(POS_LIMIT) + FRAC_W;
   localparam int TIME_W          = 24;
   localparam int SHAPE_W         = 20;
   localparam int AMP_W           = 24;
   localparam int OUT_W           = 32;
   localparam int STEPS_W         = $clog2(STEPS_PER_SHAPE + 1);
   localparam int LIMIT_W         = $clog2(POS_LIMIT + 1);
   localparam int NUM_W           = TIME_W + STEPS_W;
   localparam int REM_W           = NUM_W + FRAC_W + 1;
   localparam int CSR_IDX_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_TIME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE    = 2'd3;

   // builder datapath
   localparam int RF_W   = 40;
   localparam int ACC_W  = 44;
   localparam int PROD_W = 2 * RF_W;
   localparam int RF_AW  = 4;
   localparam int RF_N   = 16;
   localparam int OPS    = 46;
   localparam int PC_W   = $clog2(OPS);
   localparam int HALF_W = RF_W / 2;

   localparam longint Q30_ONE = 64'sd1 << 30;
   localparam longint Micro   = 1000000;
   localparam longint Steps   = STEPS_PER_SHAPE;

   typedef struct packed {
      logic                     en;
      logic [ADDR_W-1:0]        addr;
      logic signed [ROM_W-1:0]  data;
   } rom_wr_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [RF_AW-1:0] a;
      logic             b_k;
      logic [4:0]       b;
      logic             store;
      logic             emit;
      logic [RF_AW-1:0] dst;
   } op_type;

   localparam logic [2:0] OP_MUL  = 3'd0;
   localparam logic [2:0] OP_SET  = 3'd1;
   localparam logic [2:0] OP_NSET = 3'd2;
   localparam logic [2:0] OP_ADD  = 3'd3;
   localparam logic [2:0] OP_SUB  = 3'd4;

   localparam logic [RF_AW-1:0] R_EA = 4'd0;
   localparam logic [RF_AW-1:0] R_EB = 4'd1;
   localparam logic [RF_AW-1:0] R_EC = 4'd2;
   localparam logic [RF_AW-1:0] R_C1 = 4'd3;
   localparam logic [RF_AW-1:0] R_C2 = 4'd4;
   localparam logic [RF_AW-1:0] R_C3 = 4'd5;
   localparam logic [RF_AW-1:0] R_C4 = 4'd6;
   localparam logic [RF_AW-1:0] R_S1 = 4'd7;
   localparam logic [RF_AW-1:0] R_S2 = 4'd8;
   localparam logic [RF_AW-1:0] R_S3 = 4'd9;
   localparam logic [RF_AW-1:0] R_S4 = 4'd10;
   localparam logic [RF_AW-1:0] R_T  = 4'd11;
   localparam logic [RF_AW-1:0] R_GB = 4'd12;
   localparam logic [RF_AW-1:0] R_GC = 4'd13;
   localparam logic [RF_AW-1:0] R_TN = 4'd14;

   localparam logic [4:0] K_ONE = 5'd0;
   localparam logic [4:0] K_KA  = 5'd1;
   localparam logic [4:0] K_KB  = 5'd2;
   localparam logic [4:0] K_KC  = 5'd3;
   localparam logic [4:0] K_KD  = 5'd4;
   localparam logic [4:0] K_KE  = 5'd5;
   localparam logic [4:0] K_DA  = 5'd6;
   localparam logic [4:0] K_DB  = 5'd7;
   localparam logic [4:0] K_DC  = 5'd8;
   localparam logic [4:0] K_WC0 = 5'd9;
   localparam logic [4:0] K_WC1 = 5'd10;
   localparam logic [4:0] K_WC2 = 5'd11;
   localparam logic [4:0] K_WC3 = 5'd12;
   localparam logic [4:0] K_WS0 = 5'd13;
   localparam logic [4:0] K_WS1 = 5'd14;
   localparam logic [4:0] K_WS2 = 5'd15;
   localparam logic [4:0] K_WS3 = 5'd16;

   function automatic longint mulq(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // shift-subtract quotient of two nonnegative values
   function automatic longint div_pos(longint num, longint den);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int i = 62; i >= 0; i--) begin
         r = (r <<< 1) | longint'(num[i]);
         if (r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic int step_halvings(longint x0);
      longint x;
      int m;
      x = x0;
      m = 0;
      for (int i = 0; i < 64; i++) begin
         if (x > (64'sd1 <<< 29)) begin
            x = x >>> 1;
            m = m + 1;
         end
      end
      return m;
   endfunction

   function automatic longint step_reduce(longint x0);
      longint x;
      x = x0;
      for (int i = 0; i < 64; i++) begin
         if (x > (64'sd1 <<< 29)) x = x >>> 1;
      end
      return x;
   endfunction

   function automatic longint step_decay(longint x0);
      longint x;
      longint term;
      longint sum;
      int m;
      x = step_reduce(x0);
      m = step_halvings(x0);
      term = Q30_ONE;
      sum = Q30_ONE;
      for (int n = 1; n <= 24; n++) begin
         term = div_pos((term * x) >>> 30, n);
         sum = n[0] ? sum - term : sum + term;
      end
      for (int i = 0; i < m; i++) sum = mulq(sum, sum);
      return sum;
   endfunction

   function automatic logic [127:0] step_rotation(longint x0);
      longint x;
      longint term;
      longint cs;
      longint sn;
      longint t;
      longint c2;
      int m;
      x = step_reduce(x0);
      m = step_halvings(x0);
      term = Q30_ONE;
      cs = Q30_ONE;
      sn = 0;
      for (int n = 1; n <= 24; n++) begin
         term = div_pos((term * x) >>> 30, n);
         t = n[1] ? -term : term;
         if (n[0]) sn = sn + t;
         else cs = cs + t;
      end
      for (int i = 0; i < m; i++) begin
         c2 = mulq(cs, cs) - mulq(sn, sn);
         sn = 2 * mulq(sn, cs);
         cs = c2;
      end
      return {cs, sn};
   endfunction

   localparam longint KV_KA = (64'sd4310540 * Q30_ONE + Micro / 2) / Micro;
   localparam longint KV_KB = (64'sd2620200 * Q30_ONE + Micro / 2) / Micro;
   localparam longint KV_KC = (64'sd762456 * Q30_ONE + Micro / 2) / Micro;
   localparam longint KV_KD = (64'sd464924 * Q30_ONE + Micro / 2) / Micro;
   localparam longint KV_KE = (64'sd327684 * Q30_ONE + Micro / 2) / Micro;
   localparam longint XS_DA = (64'sd2948090 * Q30_ONE) / (Micro * Steps);
   localparam longint XS_DB = (64'sd2828330 * Q30_ONE) / (Micro * Steps);
   localparam longint XS_DC = (64'sd2403180 * Q30_ONE) / (Micro * Steps);
   localparam longint XS_W0 = (64'sd1193610 * Q30_ONE) / (Micro * Steps);
   localparam longint XS_W1 = (64'sd2387220 * Q30_ONE) / (Micro * Steps);
   localparam longint XS_W2 = (64'sd2592800 * Q30_ONE) / (Micro * Steps);
   localparam longint XS_W3 = (64'sd5185610 * Q30_ONE) / (Micro * Steps);
   localparam longint KV_DA = step_decay(XS_DA);
   localparam longint KV_DB = step_decay(XS_DB);
   localparam longint KV_DC = step_decay(XS_DC);
   localparam logic [127:0] ROT0 = step_rotation(XS_W0);
   localparam logic [127:0] ROT1 = step_rotation(XS_W1);
   localparam logic [127:0] ROT2 = step_rotation(XS_W2);
   localparam logic [127:0] ROT3 = step_rotation(XS_W3);

   function automatic logic signed [RF_W-1:0] k_value(logic [4:0] code);
      logic signed [RF_W-1:0] v;
      case (code)
         K_ONE:   v = RF_W'(Q30_ONE);
         K_KA:    v = RF_W'(KV_KA);
         K_KB:    v = RF_W'(KV_KB);
         K_KC:    v = RF_W'(KV_KC);
         K_KD:    v = RF_W'(KV_KD);
         K_KE:    v = RF_W'(KV_KE);
         K_DA:    v = RF_W'(KV_DA);
         K_DB:    v = RF_W'(KV_DB);
         K_DC:    v = RF_W'(KV_DC);
         K_WC0:   v = ROT0[64 +: RF_W];
         K_WC1:   v = ROT1[64 +: RF_W];
         K_WC2:   v = ROT2[64 +: RF_W];
         K_WC3:   v = ROT3[64 +: RF_W];
         K_WS0:   v = ROT0[0 +: RF_W];
         K_WS1:   v = ROT1[0 +: RF_W];
         K_WS2:   v = ROT2[0 +: RF_W];
         K_WS3:   v = ROT3[0 +: RF_W];
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic op_type mk(logic [2:0] kind, logic [RF_AW-1:0] a, logic b_k,
                                 logic [4:0] b, logic store, logic emit,
                                 logic [RF_AW-1:0] dst);
      op_type o;
      o.kind = kind;
      o.a = a;
      o.b_k = b_k;
      o.b = b;
      o.store = store;
      o.emit = emit;
      o.dst = dst;
      return o;
   endfunction

   // one table entry: response sum, emit, then advance decays and phasors
   function automatic op_type prog(logic [PC_W-1:0] pc);
      op_type o;
      case (pc)
         6'd0:  o = mk(OP_NSET, R_C1, 1'b1, K_KB, 1'b0, 1'b0, R_T);
         6'd1:  o = mk(OP_MUL,  R_C1, 1'b0, 5'(R_C2), 1'b0, 1'b0, R_T);
         6'd2:  o = mk(OP_SUB,  R_T,  1'b1, K_KB, 1'b0, 1'b0, R_T);
         6'd3:  o = mk(OP_ADD,  R_S1, 1'b1, K_KC, 1'b0, 1'b0, R_T);
         6'd4:  o = mk(OP_MUL,  R_C2, 1'b0, 5'(R_S1), 1'b0, 1'b0, R_T);
         6'd5:  o = mk(OP_SUB,  R_T,  1'b1, K_KC, 1'b0, 1'b0, R_T);
         6'd6:  o = mk(OP_MUL,  R_C1, 1'b0, 5'(R_S2), 1'b0, 1'b0, R_T);
         6'd7:  o = mk(OP_ADD,  R_T,  1'b1, K_KC, 1'b0, 1'b0, R_T);
         6'd8:  o = mk(OP_MUL,  R_S1, 1'b0, 5'(R_S2), 1'b0, 1'b0, R_T);
         6'd9:  o = mk(OP_SUB,  R_T,  1'b1, K_KB, 1'b1, 1'b0, R_GB);
         6'd10: o = mk(OP_SET,  R_C3, 1'b1, K_KD, 1'b0, 1'b0, R_T);
         6'd11: o = mk(OP_MUL,  R_C3, 1'b0, 5'(R_C4), 1'b0, 1'b0, R_T);
         6'd12: o = mk(OP_ADD,  R_T,  1'b1, K_KD, 1'b0, 1'b0, R_T);
         6'd13: o = mk(OP_SUB,  R_S3, 1'b1, K_KE, 1'b0, 1'b0, R_T);
         6'd14: o = mk(OP_MUL,  R_C4, 1'b0, 5'(R_S3), 1'b0, 1'b0, R_T);
         6'd15: o = mk(OP_ADD,  R_T,  1'b1, K_KE, 1'b0, 1'b0, R_T);
         6'd16: o = mk(OP_MUL,  R_C3, 1'b0, 5'(R_S4), 1'b0, 1'b0, R_T);
         6'd17: o = mk(OP_SUB,  R_T,  1'b1, K_KE, 1'b0, 1'b0, R_T);
         6'd18: o = mk(OP_MUL,  R_S3, 1'b0, 5'(R_S4), 1'b0, 1'b0, R_T);
         6'd19: o = mk(OP_ADD,  R_T,  1'b1, K_KD, 1'b1, 1'b0, R_GC);
         6'd20: o = mk(OP_SET,  R_EA, 1'b1, K_KA, 1'b0, 1'b0, R_T);
         6'd21: o = mk(OP_ADD,  R_EB, 1'b0, 5'(R_GB), 1'b0, 1'b0, R_T);
         6'd22: o = mk(OP_ADD,  R_EC, 1'b0, 5'(R_GC), 1'b0, 1'b1, R_T);
         6'd23: o = mk(OP_MUL,  R_EA, 1'b1, K_DA, 1'b0, 1'b0, R_EA);
         6'd24: o = mk(OP_MUL,  R_EB, 1'b1, K_DB, 1'b0, 1'b0, R_EB);
         6'd25: o = mk(OP_MUL,  R_EC, 1'b1, K_DC, 1'b0, 1'b0, R_EC);
         6'd26: o = mk(OP_SET,  R_C1, 1'b1, K_WC0, 1'b0, 1'b0, R_T);
         6'd27: o = mk(OP_SUB,  R_S1, 1'b1, K_WS0, 1'b1, 1'b0, R_TN);
         6'd28: o = mk(OP_SET,  R_S1, 1'b1, K_WC0, 1'b0, 1'b0, R_T);
         6'd29: o = mk(OP_ADD,  R_C1, 1'b1, K_WS0, 1'b1, 1'b0, R_S1);
         6'd30: o = mk(OP_MUL,  R_TN, 1'b1, K_ONE, 1'b0, 1'b0, R_C1);
         6'd31: o = mk(OP_SET,  R_C2, 1'b1, K_WC1, 1'b0, 1'b0, R_T);
         6'd32: o = mk(OP_SUB,  R_S2, 1'b1, K_WS1, 1'b1, 1'b0, R_TN);
         6'd33: o = mk(OP_SET,  R_S2, 1'b1, K_WC1, 1'b0, 1'b0, R_T);
         6'd34: o = mk(OP_ADD,  R_C2, 1'b1, K_WS1, 1'b1, 1'b0, R_S2);
         6'd35: o = mk(OP_MUL,  R_TN, 1'b1, K_ONE, 1'b0, 1'b0, R_C2);
         6'd36: o = mk(OP_SET,  R_C3, 1'b1, K_WC2, 1'b0, 1'b0, R_T);
         6'd37: o = mk(OP_SUB,  R_S3, 1'b1, K_WS2, 1'b1, 1'b0, R_TN);
         6'd38: o = mk(OP_SET,  R_S3, 1'b1, K_WC2, 1'b0, 1'b0, R_T);
         6'd39: o = mk(OP_ADD,  R_C3, 1'b1, K_WS2, 1'b1, 1'b0, R_S3);
         6'd40: o = mk(OP_MUL,  R_TN, 1'b1, K_ONE, 1'b0, 1'b0, R_C3);
         6'd41: o = mk(OP_SET,  R_C4, 1'b1, K_WC3, 1'b0, 1'b0, R_T);
         6'd42: o = mk(OP_SUB,  R_S4, 1'b1, K_WS3, 1'b1, 1'b0, R_TN);
         6'd43: o = mk(OP_SET,  R_S4, 1'b1, K_WC3, 1'b0, 1'b0, R_T);
         6'd44: o = mk(OP_ADD,  R_C4, 1'b1, K_WS3, 1'b1, 1'b0, R_S4);
         6'd45: o = mk(OP_MUL,  R_TN, 1'b1, K_ONE, 1'b0, 1'b0, R_C4);
         default: o = mk(OP_MUL, R_T, 1'b1, K_ONE, 1'b0, 1'b0, R_T);
      endcase
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== sv/srti_rom.sv =====
// Unit response table memory: one write port for the builder, two registered read ports.
// Depends on srti_pkg.
`default_nettype none
module srti_rom
   import srti_pkg::*;
(
   input  wire logic                    clock,
   input  wire rom_wr_type              wr,
   input  wire logic [ADDR_W-1:0]       rd_addr0,
   input  wire logic [ADDR_W-1:0]       rd_addr1,
   output logic signed [ROM_W-1:0]      rd_data0,
   output logic signed [ROM_W-1:0]      rd_data1
);

   logic signed [ROM_W-1:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule
`default_nettype wire

// ===== sv/srti_builder.sv =====
// Table builder: runs the decay/phasor recurrence on a shared multiplier over a small
// register file memory and writes each rounded response entry. Depends on srti_pkg.
`default_nettype none
module srti_builder
   import srti_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   output rom_wr_type rom_wr,
   output logic       done
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_M1   = 3'd2;
   localparam logic [2:0] ST_M2   = 3'd3;
   localparam logic [2:0] ST_WB   = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic signed [RF_W-1:0]     rf [RF_N];
   logic [2:0]                 state_ff, state_in;
   logic [RF_AW-1:0]           init_ff;
   logic [PC_W-1:0]            pc_ff;
   logic [ADDR_W-1:0]          entry_ff;
   logic signed [RF_W-1:0]     ra_ff, rb_ff;
   logic signed [RF_W:0]       lo_ff;
   logic signed [RF_W+HALF_W:0] prod_lo_ff;
   logic signed [RF_W+HALF_W-1:0] prod_hi_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    m;
   logic signed [PROD_W-1:0]   p;
   logic signed [RF_W-1:0]     op_b;
   logic signed [RF_W-1:0]     init_val;
   logic signed [ACC_W-1:0]    v;
   logic signed [ROM_W-1:0]    v_sat;
   op_type                     op;

   assign op   = prog(pc_ff);
   assign op_b = op.b_k ? k_value(op.b) : rb_ff;
   assign init_val = (init_ff <= R_C4) ? RF_W'(Q30_ONE) : '0;
   assign lo_ff = $signed({1'b0, op_b[HALF_W-1:0]});

   always_comb begin
      p = (PROD_W'(prod_hi_ff) <<< HALF_W) + PROD_W'(prod_lo_ff) + (PROD_W'(1) <<< 29);
      m = ACC_W'(p >>> 30);
      case (op.kind)
         OP_SET:  acc_in = m;
         OP_NSET: acc_in = -m;
         OP_ADD:  acc_in = acc_ff + m;
         OP_SUB:  acc_in = acc_ff - m;
         default: acc_in = acc_ff;
      endcase
      v = (acc_in + (ACC_W'(1) <<< 13)) >>> 14;
      if (v > ACC_W'(131071)) v_sat = 18'sd131071;
      else if (v < -ACC_W'(131072)) v_sat = -18'sd131072;
      else v_sat = ROM_W'(v);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: if (init_ff == RF_AW'(RF_N - 1)) state_in = ST_RD;
         ST_RD:   state_in = ST_M1;
         ST_M1:   state_in = ST_M2;
         ST_M2:   state_in = ST_WB;
         ST_WB: begin
            if (pc_ff == PC_W'(OPS - 1) && entry_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD;
            end
         end
         ST_DONE: state_in = ST_DONE;
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         init_ff  <= '0;
         pc_ff    <= '0;
         entry_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_INIT) init_ff <= init_ff + 1'b1;
         if (state_ff == ST_WB) begin
            if (pc_ff == PC_W'(OPS - 1)) begin
               pc_ff    <= '0;
               entry_ff <= entry_ff + 1'b1;
            end else begin
               pc_ff <= pc_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INIT) begin
         rf[init_ff] <= init_val;
      end else if (state_ff == ST_WB) begin
         if (op.kind == OP_MUL) rf[op.dst] <= RF_W'(m);
         else if (op.store) rf[op.dst] <= RF_W'(acc_in);
      end
      if (state_ff == ST_RD) begin
         ra_ff <= rf[op.a];
         rb_ff <= rf[op.b[RF_AW-1:0]];
      end
      if (state_ff == ST_M1) prod_lo_ff <= ra_ff * lo_ff;
      if (state_ff == ST_M2) prod_hi_ff <= ra_ff * $signed(op_b[RF_W-1:HALF_W]);
      if (state_ff == ST_WB && op.kind != OP_MUL) acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_wr.en <= 1'b0;
      end else begin
         rom_wr.en <= (state_ff == ST_WB) && op.emit;
      end
      rom_wr.addr <= entry_ff;
      rom_wr.data <= v_sat;
   end

   assign done = (state_ff == ST_DONE);

endmodule
`default_nettype wire

// ===== sv/srti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the table position.
// Depends on srti_pkg.
`default_nettype none
module srti_div
   import srti_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   in_num,
   input  wire logic [SHAPE_W-1:0] in_den,
   input  wire logic               in_beyond,
   output logic                    out_valid,
   output logic [QUOT_W-1:0]       out_quot,
   output logic                    out_beyond
);

   logic              valid_ff  [QUOT_W];
   logic              beyond_ff [QUOT_W];
   logic [REM_W-1:0]  rem_ff    [QUOT_W];
   logic [QUOT_W-1:0] quot_ff   [QUOT_W];

   for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
      localparam int K = QUOT_W - 1 - s;
      logic [REM_W-1:0]  rem_src;
      logic [QUOT_W-1:0] quot_src;
      logic              valid_src, beyond_src;
      logic [REM_W-1:0]  dsh;
      logic              take;

      if (s == 0) begin : g_first
         assign rem_src    = {1'b0, in_num, {FRAC_W{1'b0}}};
         assign quot_src   = '0;
         assign valid_src  = in_valid;
         assign beyond_src = in_beyond;
      end else begin : g_next
         assign rem_src    = rem_ff[s-1];
         assign quot_src   = quot_ff[s-1];
         assign valid_src  = valid_ff[s-1];
         assign beyond_src = beyond_ff[s-1];
      end

      assign dsh  = REM_W'(in_den) << K;
      assign take = rem_src >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         beyond_ff[s] <= beyond_src;
         rem_ff[s]    <= take ? rem_src - dsh : rem_src;
         quot_ff[s]   <= quot_src | (QUOT_W'(take) << K);
      end
   end

   assign out_valid  = valid_ff[QUOT_W-1];
   assign out_quot   = quot_ff[QUOT_W-1];
   assign out_beyond = beyond_ff[QUOT_W-1];

endmodule
`default_nettype wire

// ===== sv/shaper_response_table_interp_core.sv =====
// Shaper response by table lookup and interpolation: top level.
// Depends on srti_pkg, srti_rom, srti_builder and srti_div.
//
// After reset the block computes its 4000-entry unit response table and keeps busy high
// during the build (one shared multiplier; each recurrence operation steps through read,
// low multiply, high multiply, write-back). Then busy stays low and one sample is taken
// every cycle; each result passes the divider and the read, interpolate, scale and output
// registers, shows for one cycle with rsp_valid, cannot be held off. Registers may be
// written at any time but only take defined effect while no transaction is in flight.
`default_nettype none
module shaper_response_table_interp_core
   import srti_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [TIME_W-1:0]     req_sample_time,
   output logic                       rsp_valid,
   output logic signed [OUT_W-1:0]    rsp_sim_value,
   output logic                       rsp_beyond_table,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [TIME_W-1:0]     csr_wdata
);

   logic [TIME_W-1:0]        pulse_start_ff;
   logic [SHAPE_W-1:0]       shape_time_ff;
   logic signed [AMP_W-1:0]  amplitude_ff;
   logic signed [AMP_W-1:0]  baseline_ff;

   rom_wr_type               rom_wr;
   logic                     build_done;
   logic                     accept;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [TIME_W-1:0]        elapsed_ff, elapsed_in;
   logic [NUM_W-1:0]         num_ff;
   logic [SHAPE_W+LIMIT_W-1:0] limit;
   logic                     beyond_in;

   logic                     dv_valid, dv_beyond;
   logic [QUOT_W-1:0]        dv_quot;
   logic [ADDR_W-1:0]        pos, addr0, addr1;
   logic signed [ROM_W-1:0]  r0, r1;
   logic [FRAC_W-1:0]        frac_ff;
   logic                     b3_ff, b4_ff, b5_ff;
   logic signed [ROM_W:0]    diff;
   logic signed [ROM_W+FRAC_W+1:0] dprod;
   logic signed [ROM_W:0]    interp_ff;
   logic signed [AMP_W+ROM_W:0] scaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_start_ff <= '0;
         shape_time_ff  <= SHAPE_W'(65536);
         amplitude_ff   <= AMP_W'(256);
         baseline_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PULSE_START: pulse_start_ff <= csr_wdata;
            CSR_SHAPE_TIME:  shape_time_ff  <= csr_wdata[SHAPE_W-1:0];
            CSR_AMPLITUDE:   amplitude_ff   <= csr_wdata;
            CSR_BASELINE:    baseline_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   srti_builder u_builder (
      .clock (clock),
      .reset (reset),
      .rom_wr(rom_wr),
      .done  (build_done)
   );

   assign busy   = !build_done;
   assign accept = start && !busy;

   assign elapsed_in = (req_sample_time > pulse_start_ff) ?
                       req_sample_time - pulse_start_ff : '0;
   assign limit      = shape_time_ff * LIMIT_W'(POS_LIMIT);
   assign beyond_in  = (shape_time_ff == '0) || (num_ff >= NUM_W'(limit));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
      elapsed_ff <= elapsed_in;
      num_ff     <= elapsed_ff * STEPS_W'(STEPS_PER_SHAPE);
   end

   srti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_num    (num_ff),
      .in_den    (shape_time_ff),
      .in_beyond (beyond_in),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_beyond(dv_beyond)
   );

   // hold addresses in range when the position is past the end
   assign pos   = dv_quot[QUOT_W-1:FRAC_W];
   assign addr0 = dv_beyond ? '0 : pos;
   assign addr1 = dv_beyond ? '0 : pos + 1'b1;

   srti_rom u_rom (
      .clock   (clock),
      .wr      (rom_wr),
      .rd_addr0(addr0),
      .rd_addr1(addr1),
      .rd_data0(r0),
      .rd_data1(r1)
   );

   assign diff  = (ROM_W+1)'(r1) - (ROM_W+1)'(r0);
   assign dprod = diff * $signed({1'b0, frac_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         v3_ff     <= dv_valid;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         rsp_valid <= v5_ff;
      end
      frac_ff   <= dv_quot[FRAC_W-1:0];
      b3_ff     <= dv_beyond;
      interp_ff <= (ROM_W+1)'(r0) + (ROM_W+1)'(dprod >>> FRAC_W);
      b4_ff     <= b3_ff;
      scaled_ff <= amplitude_ff * interp_ff;
      b5_ff     <= b4_ff;
      rsp_beyond_table <= b5_ff;
      rsp_sim_value <= b5_ff ? OUT_W'(baseline_ff)
                             : OUT_W'(baseline_ff) + OUT_W'(scaled_ff >>> FRAC_W);
   end

`ifndef NO_ASSERTIONS
   a_busy_stays_low: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy) else $error("busy rose after table build");
   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result during table build");
   a_no_rom_write_after_build: assert property (@(posedge clock) disable iff (reset)
      $past(!busy) |-> !rom_wr.en) else $error("table written after build");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for shaper_response_table_interp_core: sample-time transactions with register
// phases, scoreboarded against an in-bench predictor that builds its own response table.
// Depends on srti_pkg and the RTL of the block.
`default_nettype none
module tb
   import srti_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000000;
   localparam int DRAIN_CYCLES   = 80;

   typedef struct {
      logic signed [OUT_W-1:0] sim_value;
      logic                    beyond_table;
   } shaper_out_type;

   class shaper_scoreboard;
      longint            unit_resp [TABLE_DEPTH];
      logic [TIME_W-1:0] start_q816;
      logic [19:0]       shape_q416;
      logic [23:0]       amp_q168;
      logic [23:0]       base_q168;
      shaper_out_type    pending [$];
      int                mismatches;
      int                checked;
      int                beyond_seen;

      function new();
         start_q816  = '0;
         shape_q416  = 20'd65536;
         amp_q168    = 24'd256;
         base_q168   = '0;
         mismatches  = 0;
         checked     = 0;
         beyond_seen = 0;
         build_table();
      endfunction

      function longint qmul(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function longint qratio(longint num);
         longint mag;
         mag = (num < 0) ? -num : num;
         mag = (mag * (64'sd1 <<< 30) + 500000) / 1000000;
         return (num < 0) ? -mag : mag;
      endfunction

      function longint reduce(longint num, output int halv);
         longint x;
         x = (num * (64'sd1 <<< 30)) / (64'sd1000000 * STEPS_PER_SHAPE);
         halv = 0;
         while (x > (64'sd1 <<< 29)) begin
            x = x >> 1;
            halv++;
         end
         return x;
      endfunction

      function longint decay_step(longint num);
         longint x, term, acc;
         int     halv;
         x = reduce(num, halv);
         term = 64'sd1 <<< 30;
         acc = term;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / n;
            acc = (n % 2 == 1) ? acc - term : acc + term;
         end
         repeat (halv) acc = qmul(acc, acc);
         return acc;
      endfunction

      function void rot_step(longint num, output longint c, output longint s);
         longint x, term, t, c2;
         int     halv;
         x = reduce(num, halv);
         term = 64'sd1 <<< 30;
         c = term;
         s = 0;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 30) / n;
            t = (((n / 2) % 2) == 1) ? -term : term;
            if (n % 2 == 1) s += t;
            else c += t;
         end
         repeat (halv) begin
            c2 = qmul(c, c) - qmul(s, s);
            s = 2 * qmul(s, c);
            c = c2;
         end
      endfunction

      function void build_table();
         longint da, db, dc, ka, kb, kc, kd, ke, ea, eb, ec, gb, gc, f, v, nc;
         longint wc [4];
         longint ws [4];
         longint pc [4];
         longint ps [4];
         longint wnum [4];
         wnum = '{1193610, 2387220, 2592800, 5185610};
         da = decay_step(2948090);
         db = decay_step(2828330);
         dc = decay_step(2403180);
         ka = qratio(4310540);
         kb = qratio(2620200);
         kc = qratio(762456);
         kd = qratio(464924);
         ke = qratio(327684);
         ea = 64'sd1 <<< 30;
         eb = ea;
         ec = ea;
         for (int j = 0; j < 4; j++) begin
            rot_step(wnum[j], wc[j], ws[j]);
            pc[j] = 64'sd1 <<< 30;
            ps[j] = 0;
         end
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            gb = -qmul(kb, pc[0]) - qmul(kb, qmul(pc[0], pc[1])) + qmul(kc, ps[0])
                 - qmul(kc, qmul(pc[1], ps[0])) + qmul(kc, qmul(pc[0], ps[1]))
                 - qmul(kb, qmul(ps[0], ps[1]));
            gc = qmul(kd, pc[2]) + qmul(kd, qmul(pc[2], pc[3])) - qmul(ke, ps[2])
                 + qmul(ke, qmul(pc[3], ps[2])) - qmul(ke, qmul(pc[2], ps[3]))
                 + qmul(kd, qmul(ps[2], ps[3]));
            f = qmul(ka, ea) + qmul(eb, gb) + qmul(ec, gc);
            v = (f + (64'sd1 <<< 13)) >>> 14;
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            unit_resp[i] = v;
            ea = qmul(ea, da);
            eb = qmul(eb, db);
            ec = qmul(ec, dc);
            for (int j = 0; j < 4; j++) begin
               nc = qmul(pc[j], wc[j]) - qmul(ps[j], ws[j]);
               ps[j] = qmul(ps[j], wc[j]) + qmul(pc[j], ws[j]);
               pc[j] = nc;
            end
         end
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
         case (idx)
            CSR_PULSE_START: start_q816 = val;
            CSR_SHAPE_TIME:  shape_q416 = val[19:0];
            CSR_AMPLITUDE:   amp_q168 = val;
            CSR_BASELINE:    base_q168 = val;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [TIME_W-1:0] st);
         shaper_out_type e;
         longint         elapsed, p, pos, frac, r0, r1, r, acc;
         elapsed = (st > start_q816) ? longint'(st - start_q816) : 0;
         acc = longint'($signed(base_q168));
         e.beyond_table = 1'b1;
         if (shape_q416 != 0) begin
            p = (elapsed * STEPS_PER_SHAPE * 65536) / longint'(shape_q416);
            pos = p >> 16;
            frac = p & 16'hFFFF;
            if (pos < TABLE_DEPTH - 1) begin
               r0 = unit_resp[pos];
               r1 = unit_resp[pos + 1];
               r = r0 + (((r1 - r0) * frac) >>> 16);
               acc += (longint'($signed(amp_q168)) * r) >>> 16;
               e.beyond_table = 1'b0;
            end
         end
         if (acc > 64'sh7FFFFFFF) acc = 64'sh7FFFFFFF;
         if (acc < -64'sh80000000) acc = -64'sh80000000;
         e.sim_value = acc[OUT_W-1:0];
         pending.insert(pending.size(), e);
      endfunction

      function void check_result(logic signed [OUT_W-1:0] sim, logic beyond);
         shaper_out_type e;
         checked++;
         if (beyond) beyond_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result sim_value=%0d beyond_table=%0b", sim, beyond);
            return;
         end
         e = pending.pop_front();
         if (sim !== e.sim_value || beyond !== e.beyond_table) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected sim_value=%0d beyond_table=%0b, got %0d %0b",
                        e.sim_value, e.beyond_table, sim, beyond);
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [TIME_W-1:0]       req_sample_time;
   logic                    rsp_valid;
   logic signed [OUT_W-1:0] rsp_sim_value;
   logic                    rsp_beyond_table;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [TIME_W-1:0]       csr_wdata;

   shaper_scoreboard sb;
   int               idle_cycles;
   int               sent;
   int               phases;

   shaper_response_table_interp_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_time  (req_sample_time),
      .rsp_valid        (rsp_valid),
      .rsp_sim_value    (rsp_sim_value),
      .rsp_beyond_table (rsp_beyond_table),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (start && !busy) sb.note_sample(req_sample_time);
         if (rsp_valid) sb.check_result(rsp_sim_value, rsp_beyond_table);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout waiting for a transaction");
            $display("tb failed");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_regs(logic [23:0] ps, logic [19:0] sh, logic [23:0] amp,
                            logic [23:0] base);
      write_reg(CSR_PULSE_START, ps);
      write_reg(CSR_SHAPE_TIME, TIME_W'(sh));
      write_reg(CSR_AMPLITUDE, amp);
      write_reg(CSR_BASELINE, base);
      phases++;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // start is raised at a falling edge, held until taken, and lowered after a burst ends
   task automatic send(logic [TIME_W-1:0] st, bit last_in_burst);
      @(negedge clock);
      start <= 1'b1;
      req_sample_time <= st;
      do @(posedge clock); while (busy);
      sent++;
      if (last_in_burst) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   function automatic logic [TIME_W-1:0] pick_sample();
      longint span, v;
      int     sel;
      sel = $urandom_range(0, 99);
      if (sel < 12 || sb.shape_q416 == 0) return TIME_W'($urandom);
      if (sel < 20) return TIME_W'($urandom_range(0, sb.start_q816));
      span = longint'(sb.shape_q416) * 11;
      v = longint'(sb.start_q816) + $urandom_range(0, 32'(span));
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      return v[TIME_W-1:0];
   endfunction

   task automatic run_random(int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left) burst = left;
         for (int k = 0; k < burst; k++) send(pick_sample(), k == burst - 1);
         left -= burst;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 8)) @(negedge clock);
      end
   endtask

   initial begin
      logic [TIME_W-1:0] directed [$];
      reset = 1'b1;
      start = 1'b0;
      req_sample_time = '0;
      csr_we = 1'b0;
      csr_index = CSR_PULSE_START;
      csr_wdata = '0;
      idle_cycles = 0;
      sent = 0;
      phases = 0;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (busy) @(negedge clock);

      // default registers: sample not after start, table edge, full range
      directed = '{24'd0, 24'd1, 24'd163, 24'd164, 24'd655032, 24'd655033, 24'd655196,
                   24'd655197, 24'd700000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h555555,
                   24'hAAAAAA, 24'd65536};
      foreach (directed[i]) send(directed[i], i == directed.size() - 1);
      drain();
      load_regs(24'd100000, 20'd65536, 24'h7FFFFF, 24'h7FFFFF);
      foreach (directed[i]) send(directed[i] + 24'd100000, i == directed.size() - 1);
      drain();
      load_regs(24'hFFFFFF, 20'd0, 24'h800000, 24'h800000);
      send(24'hFFFFFF, 0);
      send(24'd0, 0);
      send(24'd12345, 1);
      drain();

      load_regs(24'd0, 20'd0, 24'd256, 24'd1000);
      run_random(60);
      drain();
      load_regs(24'd0, 20'd1, 24'h800000, 24'h7FFFFF);
      run_random(80);
      drain();
      load_regs(24'd0, 20'hFFFFF, 24'h7FFFFF, 24'h800000);
      run_random(120);
      drain();
      load_regs(24'hFFFFFF, 20'd65536, 24'h800000, 24'd0);
      run_random(60);
      drain();
      for (int ph = 0; ph < 10; ph++) begin
         load_regs(TIME_W'($urandom_range(0, 24'hFFFFFF)),
                   ($urandom_range(0, 3) == 0) ? 20'($urandom) :
                      20'($urandom_range(4096, 262144)),
                   TIME_W'($urandom), TIME_W'($urandom));
         run_random(120);
         drain();
      end

      $display("covered %0d transactions over %0d register settings,", sent, phases);
      $display("%0d results past the table", sb.beyond_seen);
      if (sb.mismatches == 0 && sb.pending.size() == 0 && sb.checked == sent) begin
         $display("tb passed");
      end else begin
         $display("%0d mismatches, %0d results outstanding", sb.mismatches,
                  sb.pending.size());
         $display("tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
